[hdl/msd_pkg.sv]
`default_nettype none
package msd_pkg;

  localparam int unsigned ACCEL_ONE_G     = 16384;
  localparam int unsigned DISPLACE_MARGIN = 2949;

  localparam int unsigned GYRO_ROOT_W  = 24;
  localparam int unsigned ACCEL_ROOT_W = 16;
  localparam int unsigned CFG_INDEX_W  = 3;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_THRESHOLD   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHAKE_THRESHOLD    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD_MS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_COOLDOWN_MS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHAKE_COOLDOWN_MS  = 3'd4;

  localparam logic [23:0] RST_MOTION_THRESHOLD   = 24'hFFFFFF;
  localparam logic [23:0] RST_SHAKE_THRESHOLD    = 24'hFFFFFF;
  localparam logic [15:0] RST_SAMPLE_PERIOD_MS   = 16'd50;
  localparam logic [15:0] RST_MOTION_COOLDOWN_MS = 16'd1200;
  localparam logic [15:0] RST_SHAKE_COOLDOWN_MS  = 16'd2500;

  localparam logic KIND_SHAKE  = 1'b0;
  localparam logic KIND_MOTION = 1'b1;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } sample_t;

  typedef struct packed {
    logic        event_kind;
    logic [23:0] intensity;
    logic [31:0] event_time;
  } result_t;

  typedef struct packed {
    logic       capture;
    logic       commit_time;
    logic       clear_sums;
    logic       square;
    logic [1:0] axis;
    logic       sqrt_start;
    logic       filter;
    logic       load_event;
  } msd_cmd_t;

  typedef struct packed {
    logic early;
    logic sqrt_busy;
    logic hit;
    logic out_free;
  } msd_status_t;

endpackage
`default_nettype wire

[hdl/msd_isqrt.sv]
`default_nettype none
module msd_isqrt #(
  parameter int unsigned W = msd_pkg::GYRO_ROOT_W
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [2*W-1:0] radicand,
  output logic      [W-1:0]   root,
  output logic                busy
);

  localparam int unsigned STEPS = W / 2;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [2*W-1:0] rad;
  logic [W:0]     rem;
  logic [CW-1:0]  cnt;

  logic [W+2:0] t1, trial1, d1, t2, trial2, d2;
  logic         ge1, ge2;
  logic [W:0]   rem1, rem2;
  logic [W-1:0] root1, root2;

  // two result bits per cycle, restoring digit recurrence
  always_comb begin
    t1     = {rem, rad[2*W-1:2*W-2]};
    trial1 = {1'b0, root, 2'b01};
    ge1    = t1 >= trial1;
    d1     = ge1 ? (t1 - trial1) : t1;
    rem1   = d1[W:0];
    root1  = {root[W-2:0], ge1};
    t2     = {rem1, rad[2*W-3:2*W-4]};
    trial2 = {1'b0, root1, 2'b01};
    ge2    = t2 >= trial2;
    d2     = ge2 ? (t2 - trial2) : t2;
    rem2   = d2[W:0];
    root2  = {root1[W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[2*W-5:0], 4'b0000};
      rem  <= rem2;
      root <= root2;
    end
  end

endmodule
`default_nettype wire

[hdl/msd_datapath.sv]
`default_nettype none
module msd_datapath #(
  parameter int unsigned ACCEL_ONE_G     = msd_pkg::ACCEL_ONE_G,
  parameter int unsigned DISPLACE_MARGIN = msd_pkg::DISPLACE_MARGIN
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire msd_pkg::msd_cmd_t                 cmd,
  output msd_pkg::msd_status_t                   status,
  input  wire msd_pkg::sample_t                  sample,
  output msd_pkg::result_t                       result,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  input  wire logic                              cfg_valid,
  input  wire logic [msd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [31:0]                       cfg_data
);

  localparam int unsigned GW = msd_pkg::GYRO_ROOT_W;
  localparam int unsigned AW = msd_pkg::ACCEL_ROOT_W;
  localparam logic signed [17:0] ONE_G  = 18'(ACCEL_ONE_G);
  localparam logic [17:0]        MARGIN = 18'(DISPLACE_MARGIN);

  logic [23:0] motion_threshold, shake_threshold;
  logic [15:0] sample_period_ms, motion_cooldown_ms, shake_cooldown_ms;

  logic [31:0] last_sample_time, last_shake_time, last_motion_time;
  logic [23:0] filtered_rate;

  msd_pkg::sample_t smp;
  logic [31:0]      acc_sum, gyro_sum;

  logic signed [15:0] a_sel, g_sel;
  logic signed [31:0] a_sq, g_sq;

  logic [GW-1:0] gyro_root;
  logic [AW-1:0] acc_root;
  logic          gyro_busy, acc_busy;

  logic [25:0]        filt_sum;
  logic [31:0]        since_sample, since_shake, since_motion;
  logic signed [17:0] dev;
  logic [17:0]        dev_abs;
  logic               displaced, hit_shake, hit_motion;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_threshold   <= msd_pkg::RST_MOTION_THRESHOLD;
      shake_threshold    <= msd_pkg::RST_SHAKE_THRESHOLD;
      sample_period_ms   <= msd_pkg::RST_SAMPLE_PERIOD_MS;
      motion_cooldown_ms <= msd_pkg::RST_MOTION_COOLDOWN_MS;
      shake_cooldown_ms  <= msd_pkg::RST_SHAKE_COOLDOWN_MS;
    end else if (cfg_valid) begin
      case (cfg_index)
        msd_pkg::CFG_MOTION_THRESHOLD:   motion_threshold   <= cfg_data[23:0];
        msd_pkg::CFG_SHAKE_THRESHOLD:    shake_threshold    <= cfg_data[23:0];
        msd_pkg::CFG_SAMPLE_PERIOD_MS:   sample_period_ms   <= cfg_data[15:0];
        msd_pkg::CFG_MOTION_COOLDOWN_MS: motion_cooldown_ms <= cfg_data[15:0];
        msd_pkg::CFG_SHAKE_COOLDOWN_MS:  shake_cooldown_ms  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.axis)
      2'd0: begin
        a_sel = smp.accel_x;
        g_sel = smp.gyro_x;
      end
      2'd1: begin
        a_sel = smp.accel_y;
        g_sel = smp.gyro_y;
      end
      2'd2: begin
        a_sel = smp.accel_z;
        g_sel = smp.gyro_z;
      end
      default: begin
        a_sel = '0;
        g_sel = '0;
      end
    endcase
  end

  assign a_sq = 32'(a_sel) * 32'(a_sel);
  assign g_sq = 32'(g_sel) * 32'(g_sel);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp <= sample;
    end
    if (cmd.clear_sums) begin
      acc_sum  <= '0;
      gyro_sum <= '0;
    end else if (cmd.square) begin
      acc_sum  <= acc_sum + $unsigned(a_sq);
      gyro_sum <= gyro_sum + $unsigned(g_sq);
    end
  end

  // gyro magnitude in Q16.8: root of the sum scaled by 2^16
  msd_isqrt #(.W(GW)) u_gyro_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand ({gyro_sum, 16'd0}),
    .root     (gyro_root),
    .busy     (gyro_busy)
  );

  msd_isqrt #(.W(AW)) u_accel_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (acc_sum),
    .root     (acc_root),
    .busy     (acc_busy)
  );

  assign filt_sum = {1'b0, filtered_rate, 1'b0} + {2'b00, filtered_rate} + {2'b00, gyro_root};

  always_comb begin
    since_sample = smp.sample_time - last_sample_time;
    since_shake  = smp.sample_time - last_shake_time;
    since_motion = smp.sample_time - last_motion_time;
    dev          = $signed({2'b00, acc_root}) - ONE_G;
    dev_abs      = dev[17] ? $unsigned(-dev) : $unsigned(dev);
    displaced    = dev_abs > MARGIN;
    hit_shake    = (filtered_rate >= shake_threshold) &&
                   (since_shake >= {16'd0, shake_cooldown_ms});
    hit_motion   = ((filtered_rate >= motion_threshold) || displaced) &&
                   (since_motion >= {16'd0, motion_cooldown_ms});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time <= '0;
      last_shake_time  <= '0;
      last_motion_time <= '0;
      filtered_rate    <= '0;
    end else begin
      if (cmd.commit_time) begin
        last_sample_time <= smp.sample_time;
      end
      if (cmd.filter) begin
        filtered_rate <= filt_sum[25:2];
      end
      if (cmd.load_event) begin
        if (hit_shake) begin
          last_shake_time <= smp.sample_time;
        end else begin
          last_motion_time <= smp.sample_time;
        end
      end
    end
  end

  // result register, freed by a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_event) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_event) begin
      result.event_kind <= hit_shake ? msd_pkg::KIND_SHAKE : msd_pkg::KIND_MOTION;
      result.intensity  <= filtered_rate;
      result.event_time <= smp.sample_time;
    end
  end

  always_comb begin
    status.early     = since_sample < {16'd0, sample_period_ms};
    status.sqrt_busy = gyro_busy | acc_busy;
    status.hit       = hit_shake | hit_motion;
    status.out_free  = !result_valid || !result_stall;
  end

endmodule
`default_nettype wire

[hdl/msd_ctrl.sv]
`default_nettype none
module msd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output logic                      sample_stall,
  output msd_pkg::msd_cmd_t         cmd,
  input  wire msd_pkg::msd_status_t status
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_CHECK      = 3'd1;
  localparam logic [2:0] S_SQUARE     = 3'd2;
  localparam logic [2:0] S_ROOT_START = 3'd3;
  localparam logic [2:0] S_ROOT       = 3'd4;
  localparam logic [2:0] S_FILTER     = 3'd5;
  localparam logic [2:0] S_DECIDE     = 3'd6;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  logic [2:0] state, state_next;
  logic [1:0] axis, axis_next;

  assign sample_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.early) begin
          state_next = S_IDLE;
        end else begin
          cmd.commit_time = 1'b1;
          cmd.clear_sums  = 1'b1;
          axis_next       = '0;
          state_next      = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        if (axis == AXIS_LAST) begin
          state_next = S_ROOT_START;
        end else begin
          axis_next = axis + 1'b1;
        end
      end
      S_ROOT_START: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_ROOT;
      end
      S_ROOT: begin
        if (!status.sqrt_busy) begin
          state_next = S_FILTER;
        end
      end
      S_FILTER: begin
        cmd.filter = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!status.hit) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.load_event = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_event |-> status.out_free)
    else $error("result loaded while result register still held");

  a_sqrt_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |=> status.sqrt_busy)
    else $error("square root did not start");

  a_early_drop: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && status.early) |=> (state == S_IDLE && !cmd.load_event))
    else $error("early sample was not dropped");

endmodule
`default_nettype wire

[hdl/motion_shake_detector.sv]
`default_nettype none
// channel  | handshake             | payload
// sample   | sample_valid/stall    | sample   (msd_pkg::sample_t)
// result   | result_valid/stall    | result   (msd_pkg::result_t)
// config   | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// an accepted sample is worked through before the next one can transfer, the
// bulk being the 24-bit gyro square root at two bits per cycle; an early
// sample is dropped in the check step.
// synchronous reset loads the register defaults and clears the filter and
// the last sample, shake and motion times.
// a result waits in its own register under result_stall while new samples
// are taken; the block holds in its decision step only if a second event
// meets a full result register. cfg_ready is always high.
module motion_shake_detector #(
  parameter int unsigned ACCEL_ONE_G     = msd_pkg::ACCEL_ONE_G,
  parameter int unsigned DISPLACE_MARGIN = msd_pkg::DISPLACE_MARGIN
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  output logic                                 sample_stall,
  input  wire msd_pkg::sample_t                sample,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output msd_pkg::result_t                     result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [msd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                     cfg_data
);

  msd_pkg::msd_cmd_t    cmd;
  msd_pkg::msd_status_t status;

  assign cfg_ready = 1'b1;

  msd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .cmd          (cmd),
    .status       (status)
  );

  msd_datapath #(
    .ACCEL_ONE_G     (ACCEL_ONE_G),
    .DISPLACE_MARGIN (DISPLACE_MARGIN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule
`default_nettype wire

[test/motion_shake_detector_tb.sv]
`default_nettype none
module motion_shake_detector_tb;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;

  // indexes past the last register, writes there must be dropped
  localparam logic [msd_pkg::CFG_INDEX_W-1:0] CFG_NO_REGISTER = 3'd7;
  localparam logic [msd_pkg::CFG_INDEX_W-1:0] CFG_PAST_LAST   =
    msd_pkg::CFG_SHAKE_COOLDOWN_MS + 3'd1;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum {GYRO_QUIET, GYRO_TURNING, GYRO_VIOLENT, GYRO_NOISE} gyro_regime_e;

  class shake_event_predictor;
    logic [23:0] motion_thr;
    logic [23:0] shake_thr;
    logic [15:0] period_ms;
    logic [15:0] motion_cool;
    logic [15:0] shake_cool;
    logic [31:0] last_sample;
    logic [31:0] last_shake;
    logic [31:0] last_motion;
    logic [23:0] rate;
    msd_pkg::result_t pending_events[$];
    int mismatch_count;

    function new();
      motion_thr     = msd_pkg::RST_MOTION_THRESHOLD;
      shake_thr      = msd_pkg::RST_SHAKE_THRESHOLD;
      period_ms      = msd_pkg::RST_SAMPLE_PERIOD_MS;
      motion_cool    = msd_pkg::RST_MOTION_COOLDOWN_MS;
      shake_cool     = msd_pkg::RST_SHAKE_COOLDOWN_MS;
      last_sample    = '0;
      last_shake     = '0;
      last_motion    = '0;
      rate           = '0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [msd_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] d);
      case (idx)
        msd_pkg::CFG_MOTION_THRESHOLD:   motion_thr  = d[23:0];
        msd_pkg::CFG_SHAKE_THRESHOLD:    shake_thr   = d[23:0];
        msd_pkg::CFG_SAMPLE_PERIOD_MS:   period_ms   = d[15:0];
        msd_pkg::CFG_MOTION_COOLDOWN_MS: motion_cool = d[15:0];
        msd_pkg::CFG_SHAKE_COOLDOWN_MS:  shake_cool  = d[15:0];
        default: ;
      endcase
    endfunction

    // binary search on the root, one bit per step from the top
    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= n) root = trial;
      end
      return root;
    endfunction

    function void take_sample(msd_pkg::sample_t s);
      logic [31:0] t;
      logic [31:0] since;
      longint ax, ay, az, gx, gy, gz;
      longint unsigned accel_mag, gyro_mag, mix;
      int off_g;
      bit displaced;
      msd_pkg::result_t ev;
      t = s.sample_time;
      since = t - last_sample;
      if (since < 32'(period_ms)) return;
      last_sample = t;
      ax = longint'(s.accel_x);
      ay = longint'(s.accel_y);
      az = longint'(s.accel_z);
      gx = longint'(s.gyro_x);
      gy = longint'(s.gyro_y);
      gz = longint'(s.gyro_z);
      accel_mag = int_sqrt(longint'(ax * ax + ay * ay + az * az));
      gyro_mag  = int_sqrt(longint'(gx * gx + gy * gy + gz * gz) << 16);
      mix = (longint'(rate) * 3 + gyro_mag) >> 2;
      rate = mix[23:0];
      ev.intensity  = rate;
      ev.event_time = t;
      since = t - last_shake;
      if (rate >= shake_thr && since >= 32'(shake_cool)) begin
        last_shake = t;
        ev.event_kind = msd_pkg::KIND_SHAKE;
        pending_events.push_back(ev);
        return;
      end
      off_g = int'(accel_mag) - int'(msd_pkg::ACCEL_ONE_G);
      if (off_g < 0) off_g = -off_g;
      displaced = off_g > int'(msd_pkg::DISPLACE_MARGIN);
      since = t - last_motion;
      if ((rate >= motion_thr || displaced) && since >= 32'(motion_cool)) begin
        last_motion = t;
        ev.event_kind = msd_pkg::KIND_MOTION;
        pending_events.push_back(ev);
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    task match_event(msd_pkg::result_t got);
      msd_pkg::result_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("event with none pending, kind %0d time %0h",
                         got.event_kind, got.event_time));
        return;
      end
      want = pending_events.pop_front();
      if (got.event_kind !== want.event_kind)
        report($sformatf("time %0h kind %0d want %0d", want.event_time,
                         got.event_kind, want.event_kind));
      if (got.intensity !== want.intensity)
        report($sformatf("time %0h intensity %0h want %0h", want.event_time,
                         got.intensity, want.intensity));
      if (got.event_time !== want.event_time)
        report($sformatf("event_time %0h want %0h", got.event_time, want.event_time));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  msd_pkg::sample_t sample_bus;
  logic result_valid;
  logic result_stall;
  msd_pkg::result_t result_bus;
  logic cfg_valid;
  logic cfg_ready;
  logic [msd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  shake_event_predictor shake_calc;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned cycle_count = 0;
  logic [31:0] clock_ms;
  gyro_regime_e gyro_regime;

  motion_shake_detector i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample_bus),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_bus),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver side: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall = 1'b1;
      hold_left--;
    end else begin
      result_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) shake_calc.match_event(result_bus);
  end

  function automatic logic [15:0] rand_s16(int lim);
    int v;
    v = int'($urandom_range(2 * lim)) - lim;
    return v[15:0];
  endfunction

  function automatic logic [31:0] next_stamp();
    int unsigned p;
    int unsigned k;
    p = 32'(shake_calc.period_ms);
    k = $urandom_range(99);
    if (k < 10) clock_ms += (p == 0) ? 0 : $urandom_range(p - 1);
    else if (k < 75) clock_ms += p + $urandom_range(60);
    else if (k < 95) clock_ms += p + $urandom_range(3000);
    else clock_ms = $urandom();
    return clock_ms;
  endfunction

  // gyro level persists for a few samples so the filter can settle
  function automatic msd_pkg::sample_t make_sample(logic [31:0] stamp);
    msd_pkg::sample_t s;
    int lim;
    int unsigned pick;
    s.sample_time = stamp;
    if ($urandom_range(7) == 0) gyro_regime = gyro_regime_e'($urandom_range(3));
    case (gyro_regime)
      GYRO_QUIET:   lim = 150;
      GYRO_TURNING: lim = 4000;
      default:      lim = 32767;
    endcase
    if (gyro_regime == GYRO_NOISE) begin
      s.gyro_x = 16'($urandom());
      s.gyro_y = 16'($urandom());
      s.gyro_z = 16'($urandom());
    end else begin
      s.gyro_x = rand_s16(lim);
      s.gyro_y = rand_s16(lim);
      s.gyro_z = rand_s16(lim);
    end
    pick = $urandom_range(9);
    if (pick < 7) begin
      s.accel_x = rand_s16(2000);
      s.accel_y = rand_s16(2000);
      s.accel_z = 16'(int'(msd_pkg::ACCEL_ONE_G) + int'($signed(rand_s16(3500))));
      if ($urandom_range(1)) s.accel_z = -s.accel_z;
    end else if (pick < 9) begin
      s.accel_x = 16'($urandom());
      s.accel_y = 16'($urandom());
      s.accel_z = 16'($urandom());
    end else begin
      s.accel_x = '0;
      s.accel_y = '0;
      s.accel_z = '0;
    end
    return s;
  endfunction

  // starts and ends on a falling edge; valid stays up for back-to-back transfers
  task automatic send_sample(msd_pkg::sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample_valid = 1'b1;
    sample_bus = s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    shake_calc.take_sample(s);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [31:0] t, int ax, int ay, int az,
                             int gx, int gy, int gz);
    msd_pkg::sample_t s;
    s.sample_time = t;
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.gyro_x = 16'(gx);
    s.gyro_y = 16'(gy);
    s.gyro_z = 16'(gz);
    send_sample(s);
  endtask

  task automatic write_cfg(logic [msd_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shake_calc.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // junk in the unused upper bits must be dropped by the block
  task automatic set_regs(logic [23:0] m_thr, logic [23:0] s_thr, logic [15:0] per,
                          logic [15:0] m_cool, logic [15:0] s_cool);
    write_cfg(msd_pkg::CFG_MOTION_THRESHOLD, {8'($urandom()), m_thr});
    write_cfg(msd_pkg::CFG_SHAKE_THRESHOLD, {8'($urandom()), s_thr});
    write_cfg(msd_pkg::CFG_SAMPLE_PERIOD_MS, {16'($urandom()), per});
    write_cfg(msd_pkg::CFG_MOTION_COOLDOWN_MS, {16'($urandom()), m_cool});
    write_cfg(msd_pkg::CFG_SHAKE_COOLDOWN_MS, {16'($urandom()), s_cool});
  endtask

  task automatic random_regs();
    set_regs(24'($urandom_range(800000, 1000)), 24'($urandom_range(9000000, 500000)),
             16'($urandom_range(80)), 16'($urandom_range(400)),
             16'($urandom_range(400)));
  endtask

  task automatic set_idle(idle_mode_e m);
    send_idle_pct  = (m == IDLE_SENDER) ? 72 : (m == IDLE_BOTH) ? 29 : 0;
    recv_stall_pct = (m == IDLE_RECEIVER) ? 72 : (m == IDLE_BOTH) ? 29 : 0;
  endtask

  // wait out every pending event, then the tail of the last sample
  task automatic drain();
    sample_valid = 1'b0;
    while (shake_calc.pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_sample(make_sample(next_stamp()));
  endtask

  initial begin
    shake_calc     = new();
    rst            = 1'b1;
    sample_valid   = 1'b0;
    sample_bus     = '0;
    result_stall   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    clock_ms       = '0;
    gyro_regime    = GYRO_QUIET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    write_cfg(CFG_NO_REGISTER, $urandom());
    write_cfg(CFG_PAST_LAST, $urandom());

    // register defaults: only acceleration can raise motion events
    send_fields(32'd0, 0, 0, 0, 0, 0, 0);                  // early right after reset
    send_fields(32'd49, -32768, -32768, -32768, 0, 0, 0);  // one ms short of the period
    send_fields(32'd50, 0, 0, 16384, 0, 0, 0);
    send_fields(32'd100, 0, 0, 16384 + 2949, 0, 0, 0);     // on the margin, not displaced
    send_fields(32'd1200, 0, 0, 16384 + 2950, 0, 0, 0);    // displaced, cooldown just met
    send_fields(32'd1300, 0, 0, 16384 - 2950, 0, 0, 0);
    send_fields(32'd2400, 32767, 32767, 32767, 32767, 32767, 32767);
    send_fields(32'd2450, -32768, -32768, -32768, -32768, -32768, -32768);
    drain();

    write_cfg(msd_pkg::CFG_SHAKE_THRESHOLD, 32'hA5000000);
    send_fields(32'd2500, 0, 16384, 0, 5, -7, 3);
    send_fields(32'd2550, 0, 0, 0, -32768, 32767, 0);
    send_fields(32'hFFFFFFF0, -16384, 0, 0, 100, 100, 100);  // far ahead, time wraps next
    send_fields(32'h00000010, 0, 0, 0, 0, 0, 0);
    send_fields(32'h00000022, 0, 0, 0, 0, 0, 0);
    drain();

    set_regs(24'd60000, 24'd2500000, 16'd50, 16'd0, 16'd100);
    set_idle(IDLE_NONE);
    run_random(80);
    drain();
    random_regs();
    set_idle(IDLE_SENDER);
    run_random(80);
    drain();
    random_regs();
    set_idle(IDLE_RECEIVER);
    run_random(80);
    drain();
    random_regs();
    set_idle(IDLE_BOTH);
    run_random(80);
    drain();

    // every accepted sample shakes; the long hold-off backs the block up
    set_regs(24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000);
    set_idle(IDLE_NONE);
    hold_left = HOLD_CYCLES;
    run_random(60);
    drain();
    set_regs(24'h000000, 24'hFFFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    set_idle(IDLE_BOTH);
    run_random(40);
    drain();
    set_regs(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_idle(IDLE_SENDER);
    run_random(40);
    drain();
    random_regs();
    set_idle(IDLE_RECEIVER);
    run_random(50);
    drain();
    run_random(50);
    drain();
    random_regs();
    set_idle(IDLE_NONE);
    run_random(40);
    drain();

    if (shake_calc.mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
